>>> hw/rtl/bht_pkg.sv
// ----------------------------------------------------------------------------
// bht_pkg: shared types and constants for the bucketed hash table
// Register indexes, status codes, hash modes and controller commands.
// ----------------------------------------------------------------------------
package bht_pkg;

	localparam int DEF_MAX_BUCKETS = 16;
	localparam int DEF_MAX_SLOTS = 4;
	localparam int DEF_SPILL_DEPTH = 8;
	localparam int DEF_RECORD_VALUE_WIDTH = 32;

	localparam logic [1:0] REG_NUM_BUCKETS = 2'd0;
	localparam logic [1:0] REG_BUCKET_SIZE = 2'd1;
	localparam logic [1:0] REG_HASH_MODE = 2'd2;

	localparam logic [1:0] HASH_MOD = 2'd0;
	localparam logic [1:0] HASH_MID = 2'd1;
	localparam logic [1:0] HASH_LIN = 2'd2;
	localparam logic [1:0] HASH_UNUSED = 2'd3;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic [2:0] ST_STORED = 3'd0;
	localparam logic [2:0] ST_STORED_OVF = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_FOUND = 3'd3;
	localparam logic [2:0] ST_FOUND_OVF = 3'd4;
	localparam logic [2:0] ST_ABSENT = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture input word, start hash
		logic hash_step;  // advance hashing unit
		logic slot_rd;    // issue bucket slot read
		logic slot_chk;   // evaluate returned slot
		logic spill_rd;   // issue overflow read
		logic spill_chk;  // evaluate returned overflow entry
		logic finish;     // load the result register
	} bht_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hash_done;
		logic bad_mode;
		logic slot_last;
		logic spill_last;
		logic hit;        // slot/entry check decides the outcome
		logic stop;       // bucket scan ends without result (empty slot on search)
	} bht_sts_t;

endpackage

>>> hw/rtl/bht_if.sv
// ----------------------------------------------------------------------------
// bht_if: valid/ready channels
// Generic payload stream and configuration write channel.
// ----------------------------------------------------------------------------
interface bht_stream_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bht_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> hw/rtl/bht_ctrl.sv
// ----------------------------------------------------------------------------
// bht_ctrl: controller state machine
// Sequences hashing, bucket scan, overflow scan and result hand-off.
// ----------------------------------------------------------------------------
module bht_ctrl import bht_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_busy,
	input  bht_sts_t sts,
	output bht_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HASH = 3'd1;
	localparam logic [2:0] S_SRD = 3'd2;
	localparam logic [2:0] S_SCHK = 3'd3;
	localparam logic [2:0] S_ORD = 3'd4;
	localparam logic [2:0] S_OCHK = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.hash_done) state_d = sts.bad_mode ? S_DONE : S_SRD;
			end
			S_SRD: begin
				cmd.slot_rd = 1'b1;
				state_d = S_SCHK;
			end
			S_SCHK: begin
				cmd.slot_chk = 1'b1;
				if (sts.hit || sts.stop) state_d = S_DONE;
				else if (sts.slot_last) state_d = S_ORD;
				else state_d = S_SRD;
			end
			S_ORD: begin
				cmd.spill_rd = 1'b1;
				state_d = S_OCHK;
			end
			S_OCHK: begin
				cmd.spill_chk = 1'b1;
				if (sts.hit || sts.spill_last) state_d = S_DONE;
				else state_d = S_ORD;
			end
			S_DONE: begin
				if (!out_busy) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

>>> hw/rtl/bht_dp.sv
// ----------------------------------------------------------------------------
// bht_dp: datapath
// Hash unit, slot and overflow memories, and the result register.
// ----------------------------------------------------------------------------
module bht_dp import bht_pkg::*; #(
	parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
	parameter int MAX_SLOTS = DEF_MAX_SLOTS,
	parameter int SPILL_DEPTH = DEF_SPILL_DEPTH,
	parameter int RECORD_VALUE_WIDTH = DEF_RECORD_VALUE_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  bht_cmd_t    cmd,
	output bht_sts_t    sts,
	input  logic        in_command,
	input  logic [31:0] in_key,
	input  logic [31:0] in_value,
	input  logic [4:0]  num_buckets,
	input  logic [2:0]  bucket_size,
	input  logic [1:0]  hash_mode,
	output logic [2:0]  res_status,
	output logic [31:0] res_value
);
	localparam int DEPTH = MAX_BUCKETS * MAX_SLOTS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int OW = (SPILL_DEPTH > 1) ? $clog2(SPILL_DEPTH) : 1;
	localparam int RVW = RECORD_VALUE_WIDTH;
	localparam int BCD_DIGITS = 20; // enough for any square of a 32-bit magnitude

	// Hash states
	localparam logic [2:0] H_MAG = 3'd0;
	localparam logic [2:0] H_SQ = 3'd1;
	localparam logic [2:0] H_ACC = 3'd2;
	localparam logic [2:0] H_BCD = 3'd3;
	localparam logic [2:0] H_MOD = 3'd4;
	localparam logic [2:0] H_END = 3'd5;
	localparam logic [2:0] H_MID = 3'd6;

	logic        cmd_q;
	logic [31:0] key_q;
	logic [RVW-1:0] val_q;
	logic [1:0]  mode_q;
	logic [8:0]  nb_q;
	logic [SW:0] ns_q;

	logic [2:0]  hst_q;
	logic [63:0] acc_q;   // square, then remainder
	logic [63:0] tmp_q;   // value to be reduced modulo the bucket count
	logic [5:0]  cnt_q;
	logic [BW-1:0] bucket_q;
	logic [31:0] mulp_q;  // partial products of the square
	logic [1:0]  mph_q;
	logic [4*BCD_DIGITS-1:0] bcd_q;

	logic [SW:0] slot_q;
	logic [OW:0] sp_q;
	logic        found_free_q;
	logic [2:0]  wst_q;
	logic [31:0] wval_q;

	logic [DEPTH-1:0] used_q;
	logic [SPILL_DEPTH-1:0] sused_q;
	logic [31:0] skey_mem [DEPTH];
	logic [RVW-1:0] sval_mem [DEPTH];
	logic [31:0] okey_mem [SPILL_DEPTH];
	logic [RVW-1:0] oval_mem [SPILL_DEPTH];
	logic [31:0] rkey_q;
	logic [RVW-1:0] rval_q;
	logic        rused_q;

	logic [31:0] mag;
	logic [4:0]  nbc;
	logic [2:0]  nsc;
	logic [AW-1:0] slot_addr;
	logic [OW-1:0] sp_addr;
	logic [63:0] nbw;
	logic [4*BCD_DIGITS-1:0] bcd_adj;
	logic [4:0]  dig_w;
	logic [4:0]  mid_w;
	logic [4:0]  lo_w;
	logic [7:0]  pair_w;
	logic [6:0]  mid2;

	assign mag = key_q[31] ? (~key_q + 32'd1) : key_q;
	assign nbc = (num_buckets == 5'd0) ? 5'd1 : num_buckets;
	assign nsc = (bucket_size == 3'd0) ? 3'd1 : bucket_size;
	assign nbw = {55'd0, nb_q};
	assign slot_addr = AW'(bucket_q * MAX_SLOTS + slot_q[SW-1:0]);
	assign sp_addr = sp_q[OW-1:0];

	// Square done in four 16x16 partial products, then digit work.
	logic [15:0] pa, pb;
	always_comb begin
		case (mph_q)
			2'd0: begin pa = mag[15:0]; pb = mag[15:0]; end
			2'd1: begin pa = mag[31:16]; pb = mag[15:0]; end
			2'd2: begin pa = mag[15:0]; pb = mag[31:16]; end
			default: begin pa = mag[31:16]; pb = mag[31:16]; end
		endcase
	end

	// Decimal digits of the square: each digit of five or more gets three added
	// before the next bit is shifted in.
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
		end
	end

	// Digit count and the two middle digits of the square.
	always_comb begin
		dig_w = '0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) dig_w = 5'(i + 1);
		end
	end
	assign mid_w = dig_w >> 1;
	assign lo_w = (mid_w != 5'd0) ? mid_w - 5'd1 : 5'd0;
	assign pair_w = 8'(bcd_q >> {lo_w, 2'b00});
	assign mid2 = 7'({pair_w[7:4], 3'b000}) + 7'({pair_w[7:4], 1'b0}) + 7'(pair_w[3:0]);

	// Capture, hashing: reduce modulo the bucket count by restoring subtraction.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_command;
			key_q <= in_key;
			val_q <= RVW'(in_value);
			mode_q <= hash_mode;
			nb_q <= ((nbc > 5'(MAX_BUCKETS)) && (MAX_BUCKETS < 32)) ?
				9'(MAX_BUCKETS) : 9'(nbc);
			ns_q <= (nsc > 3'(MAX_SLOTS) && MAX_SLOTS < 8) ?
				(SW+1)'(MAX_SLOTS) : (SW+1)'(nsc);
			hst_q <= H_MAG;
			mph_q <= 2'd0;
			slot_q <= '0;
			sp_q <= '0;
		end else if (cmd.hash_step) begin
			unique case (hst_q)
				H_MAG: begin
					acc_q <= '0;
					unique case (mode_q)
						HASH_MOD: begin tmp_q <= {32'd0, mag}; hst_q <= H_MOD;
							cnt_q <= 6'd63; end
						HASH_LIN: begin
							tmp_q <= ({32'd0, mag} << 5) - {32'd0, mag} + 64'd17;
							hst_q <= H_MOD; cnt_q <= 6'd63; end
						HASH_MID: hst_q <= H_SQ;
						default: hst_q <= H_END;
					endcase
				end
				H_SQ: begin
					// the phase counter wraps back to zero after the fourth product
					mulp_q <= pa * pb;
					mph_q <= mph_q + 2'd1;
					case (mph_q)
						2'd1: acc_q <= acc_q + {32'd0, mulp_q};
						2'd2, 2'd3: acc_q <= acc_q + ({32'd0, mulp_q} << 16);
						default: acc_q <= acc_q;
					endcase
					if (mph_q == 2'd3) hst_q <= H_ACC;
				end
				H_ACC: begin
					// last partial product (high*high), then start the digit conversion
					acc_q <= acc_q + ({32'd0, mulp_q} << 32);
					bcd_q <= '0;
					cnt_q <= 6'd63;
					hst_q <= H_BCD;
				end
				H_BCD: begin
					// one bit of the square a cycle, from the top
					bcd_q <= {bcd_adj[4*BCD_DIGITS-2:0], acc_q[cnt_q]};
					if (cnt_q == 6'd0) hst_q <= H_MID;
					else cnt_q <= cnt_q - 6'd1;
				end
				H_MID: begin
					// the middle pair is below 128, so seven remainder steps suffice
					acc_q <= '0;
					tmp_q <= {57'd0, mid2};
					cnt_q <= 6'd6;
					hst_q <= H_MOD;
				end
				H_MOD: begin
					// remainder kept in acc_q, one bit a cycle from the top
					if ({acc_q[62:0], tmp_q[cnt_q]} >= nbw)
						acc_q <= {acc_q[62:0], tmp_q[cnt_q]} - nbw;
					else acc_q <= {acc_q[62:0], tmp_q[cnt_q]};
					if (cnt_q == 6'd0) hst_q <= H_END;
					else cnt_q <= cnt_q - 6'd1;
				end
				H_END: bucket_q <= BW'(acc_q);
				default: hst_q <= H_END;
			endcase
		end
		if (cmd.slot_chk) slot_q <= slot_q + 1'b1;
		if (cmd.spill_chk) sp_q <= sp_q + 1'b1;
	end

	// Memory reads, registered.
	always_ff @(posedge clk) begin
		if (cmd.slot_rd) begin
			rkey_q <= skey_mem[slot_addr];
			rval_q <= sval_mem[slot_addr];
			rused_q <= used_q[slot_addr];
		end else if (cmd.spill_rd) begin
			rkey_q <= okey_mem[sp_addr];
			rval_q <= oval_mem[sp_addr];
			rused_q <= sused_q[sp_addr];
		end
	end

	// Status to the controller and the decision on the returned entry.
	always_comb begin
		sts.hash_done = (hst_q == H_END);
		sts.bad_mode = (mode_q != HASH_MOD) && (mode_q != HASH_MID)
			&& (mode_q != HASH_LIN);
		sts.slot_last = (slot_q + 1'b1 == ns_q);
		sts.spill_last = (sp_q + 1'b1 == (OW+1)'(SPILL_DEPTH));
		sts.hit = 1'b0;
		sts.stop = 1'b0;
		if (cmd_q == CMD_INSERT) sts.hit = !rused_q;
		else if (cmd.slot_chk) begin
			sts.hit = rused_q && (rkey_q == key_q);
			sts.stop = !rused_q;
		end else sts.hit = rused_q && (rkey_q == key_q);
	end

	// Memory writes on insert.
	always_ff @(posedge clk) begin
		if (cmd.slot_chk && cmd_q == CMD_INSERT && !rused_q) begin
			skey_mem[slot_addr] <= key_q;
			sval_mem[slot_addr] <= val_q;
		end
		if (cmd.spill_chk && cmd_q == CMD_INSERT && !rused_q) begin
			okey_mem[sp_addr] <= key_q;
			oval_mem[sp_addr] <= val_q;
		end
	end

	// Used bits, working result and the output result register. The output
	// register only changes on finish, so a waiting word stays untouched while
	// the next request is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			sused_q <= '0;
			found_free_q <= 1'b0;
			wst_q <= ST_STORED;
			wval_q <= '0;
			res_status <= ST_STORED;
			res_value <= '0;
		end else begin
			if (cmd.load) found_free_q <= 1'b0;
			if (cmd.slot_chk && sts.hit) begin
				found_free_q <= 1'b1;
				if (cmd_q == CMD_INSERT) used_q[slot_addr] <= 1'b1;
				wst_q <= (cmd_q == CMD_INSERT) ? ST_STORED : ST_FOUND;
				wval_q <= (cmd_q == CMD_INSERT) ? 32'd0 : 32'(rval_q);
			end
			if (cmd.spill_chk && sts.hit) begin
				found_free_q <= 1'b1;
				if (cmd_q == CMD_INSERT) sused_q[sp_addr] <= 1'b1;
				wst_q <= (cmd_q == CMD_INSERT) ? ST_STORED_OVF : ST_FOUND_OVF;
				wval_q <= (cmd_q == CMD_INSERT) ? 32'd0 : 32'(rval_q);
			end
			if (cmd.finish) begin
				if (found_free_q) begin
					res_status <= wst_q;
					res_value <= wval_q;
				end else begin
					res_status <= (cmd_q == CMD_INSERT) ? ST_FULL : ST_ABSENT;
					res_value <= '0;
				end
			end
		end
	end
endmodule

>>> hw/rtl/bucketed_hash_table_core.sv
// ----------------------------------------------------------------------------
// bucketed_hash_table_core: bucketed hash table with an overflow area
// Insert and search of key-value records; one result word per request word.
// ----------------------------------------------------------------------------
// One request word is handled at a time. After the word is taken, hashing
// reduces one remainder bit a cycle for the modulo and linear modes, works
// through four partial products, a 64-step decimal conversion and a
// seven-step remainder for mid-square, and skips straight to its end for the
// unused mode. Each bucket slot and each overflow entry scanned takes a read
// state and a check state through the shared read register, and then the
// result is handed off. The result waits in an output register while the
// next word is already taken and processed; that word holds in its last step
// until the output register is free.
module bucketed_hash_table_core import bht_pkg::*; #(
	parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
	parameter int MAX_SLOTS = DEF_MAX_SLOTS,
	parameter int SPILL_DEPTH = DEF_SPILL_DEPTH,
	parameter int RECORD_VALUE_WIDTH = DEF_RECORD_VALUE_WIDTH
) (
	input logic clk,
	input logic arst_n,
	bht_cfg_if.sink cfg,
	bht_stream_if.sink req,   // data: {command, key, value_in}
	bht_stream_if.source rsp  // data: {status, value_out}
);
	logic [4:0] num_buckets_q;
	logic [2:0] bucket_size_q;
	logic [1:0] hash_mode_q;
	bht_cmd_t cmd;
	bht_sts_t sts;
	logic in_ready, out_valid_q;
	logic [2:0] res_status;
	logic [31:0] res_value;

	// Configuration registers.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_buckets_q <= 5'd11;
			bucket_size_q <= 3'd3;
			hash_mode_q <= HASH_MOD;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_NUM_BUCKETS: num_buckets_q <= cfg.wdata[4:0];
				REG_BUCKET_SIZE: bucket_size_q <= cfg.wdata[2:0];
				REG_HASH_MODE: hash_mode_q <= cfg.wdata[1:0];
				default: ;
			endcase
		end
	end

	bht_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready,
		.out_busy(out_valid_q), .sts, .cmd
	);

	bht_dp #(
		.MAX_BUCKETS(MAX_BUCKETS), .MAX_SLOTS(MAX_SLOTS),
		.SPILL_DEPTH(SPILL_DEPTH), .RECORD_VALUE_WIDTH(RECORD_VALUE_WIDTH)
	) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_command(req.data[64]), .in_key(req.data[63:32]),
		.in_value(req.data[31:0]),
		.num_buckets(num_buckets_q), .bucket_size(bucket_size_q),
		.hash_mode(hash_mode_q), .res_status, .res_value
	);

	// Output word valid flag.
	assign req.ready = in_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.finish) out_valid_q <= 1'b1;
		else if (rsp.ready) out_valid_q <= 1'b0;
	end
	assign rsp.valid = out_valid_q;
	assign rsp.data = {res_status, res_value};

	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> rsp.valid) else $error("result lost");
	a_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.finish) else $error("overlap");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("waiting result changed");
endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking regression for bucketed_hash_table_core
// Insert and search words go through a queue into a clocked driver. A local
// model of the buckets and the overflow area predicts every response word,
// and a clocked monitor compares each response with the oldest prediction.
// The run steps through several geometries and hash methods, including
// register values outside the legal range and the unused hash method. It also
// varies idling on both channels and holds off the response side for a long
// stretch so that the core stalls its input.
// ----------------------------------------------------------------------------
module testbench;
	import bht_pkg::*;

	localparam int NB = DEF_MAX_BUCKETS;
	localparam int NS = DEF_MAX_SLOTS;
	localparam int NSPILL = DEF_SPILL_DEPTH;
	localparam int PHASE_ITEMS = 210;

	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;

	typedef struct packed {
		logic cmd;
		logic [31:0] key;
		logic [31:0] val;
	} request_t;

	typedef struct packed {
		logic [2:0] st;
		logic [31:0] val;
	} answer_t;

	logic clk;
	logic arst_n;

	bht_cfg_if cfg ();
	bht_stream_if #(.W(65)) req ();
	bht_stream_if #(.W(35)) rsp ();

	bucketed_hash_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg.sink),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// Local copy of the registers and the table.
	logic [4:0] m_buckets;
	logic [2:0] m_slots;
	logic [1:0] m_mode;
	logic tab_used [NB*NS];
	logic [31:0] tab_key [NB*NS];
	logic [31:0] tab_val [NB*NS];
	logic ovf_used [NSPILL];
	logic [31:0] ovf_key [NSPILL];
	logic [31:0] ovf_val [NSPILL];

	request_t pending_words[$];
	answer_t expected_answers[$];
	request_t cur_word;
	int idle_mode;
	int errors;
	int words_sent;
	int answers_seen;
	int cfg_writes;
	int hold_left;
	logic hold_kick;
	int finds;
	int ovf_finds;

	// Clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Two middle decimal digits of the square of a magnitude.
	function automatic logic [63:0] mid_digits(input logic [63:0] mag);
		logic [63:0] sq;
		logic [63:0] t;
		logic [63:0] div;
		int digits;
		sq = mag * mag;
		t = sq;
		div = 64'd1;
		digits = 0;
		while (t > 0) begin
			t = t / 10;
			digits++;
		end
		for (int i = 0; i < digits / 2 - 1; i++) begin
			div = div * 10;
		end
		return (sq / div) % 100;
	endfunction

	// Bucket of a key under the current registers, or -1 for the unused method.
	function automatic int bucket_index(input logic [31:0] key);
		logic [63:0] n;
		logic [63:0] mag;
		logic [31:0] mag32;
		n = (m_buckets == 0) ? 64'd1 : (m_buckets > NB) ? 64'(NB) : 64'(m_buckets);
		mag32 = key[31] ? (~key + 32'd1) : key;
		mag = {32'd0, mag32};
		if (mag == 0 && key != 0) begin
			mag = 64'h8000_0000;
		end
		case (m_mode)
			HASH_MOD: return int'(mag % n);
			HASH_MID: return int'(mid_digits(mag) % n);
			HASH_LIN: return int'((64'd31 * mag + 64'd17) % n);
			default: return -1;
		endcase
	endfunction

	// Apply one accepted request word to the table and queue its answer.
	function automatic void table_apply(input request_t w);
		answer_t a;
		int b;
		int slots;
		int idx;
		bit done;
		b = bucket_index(w.key);
		slots = (m_slots == 0) ? 1 : (m_slots > NS) ? NS : int'(m_slots);
		a.val = '0;
		done = 0;
		if (b < 0) begin
			a.st = (w.cmd == CMD_SEARCH) ? ST_ABSENT : ST_FULL;
		end else if (w.cmd == CMD_INSERT) begin
			a.st = ST_FULL;
			for (int i = 0; i < slots && !done; i++) begin
				idx = b * NS + i;
				if (!tab_used[idx]) begin
					tab_used[idx] = 1'b1;
					tab_key[idx] = w.key;
					tab_val[idx] = w.val;
					a.st = ST_STORED;
					done = 1;
				end
			end
			for (int i = 0; i < NSPILL && !done; i++) begin
				if (!ovf_used[i]) begin
					ovf_used[i] = 1'b1;
					ovf_key[i] = w.key;
					ovf_val[i] = w.val;
					a.st = ST_STORED_OVF;
					done = 1;
				end
			end
		end else begin
			a.st = ST_ABSENT;
			for (int i = 0; i < slots && !done; i++) begin
				idx = b * NS + i;
				if (!tab_used[idx]) begin
					done = 1;
				end else if (tab_key[idx] == w.key) begin
					a.st = ST_FOUND;
					a.val = tab_val[idx];
					done = 1;
				end
			end
			for (int i = 0; i < NSPILL && !done; i++) begin
				if (ovf_used[i] && ovf_key[i] == w.key) begin
					a.st = ST_FOUND_OVF;
					a.val = ovf_val[i];
					done = 1;
				end
			end
		end
		expected_answers.push_back(a);
	endfunction

	// Request driver: takes the next word from the queue, with optional gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!req.valid || req.ready) begin
				if (req.valid) begin
					table_apply(cur_word);
					words_sent++;
				end
				if (pending_words.size() > 0 &&
				    !((idle_mode == IDLE_SEND && $urandom_range(99) < 85) ||
				      (idle_mode == IDLE_BOTH && $urandom_range(99) < 18))) begin
					cur_word = pending_words.pop_front();
					req.valid <= 1'b1;
					req.data <= cur_word;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off of the response side, counted on its own.
	always @(posedge clk) begin
		if (hold_kick) begin
			hold_left <= 600;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Response monitor: compares each word with the oldest prediction.
	always @(posedge clk) begin
		answer_t got;
		answer_t exp_a;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				answers_seen++;
				if (expected_answers.size() == 0) begin
					$display("%0t: unexpected response word status %0d value %h",
						$time, got.st, got.val);
					errors++;
				end else begin
					exp_a = expected_answers.pop_front();
					if (got.st == ST_FOUND) finds++;
					if (got.st == ST_FOUND_OVF) ovf_finds++;
					if (got.st !== exp_a.st) begin
						$display("%0t: status mismatch, expected %0d actual %0d",
							$time, exp_a.st, got.st);
						errors++;
					end
					if (got.val !== exp_a.val) begin
						$display("%0t: value mismatch, expected %h actual %h",
							$time, exp_a.val, got.val);
						errors++;
					end
				end
			end
			if (hold_left > 1 || hold_kick) begin
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 85) ||
					(idle_mode == IDLE_BOTH && $urandom_range(99) < 18));
			end
		end
	end

	// Wait until every queued word has been answered.
	task automatic drain();
		while (pending_words.size() > 0 || req.valid || expected_answers.size() > 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
	endtask

	// One register write while the core is idle; on about half the writes the upper data bits are random.
	task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
		logic [31:0] wd;
		wd = value;
		if ($urandom_range(1)) begin
			wd = value | ($urandom() & ~((index == REG_NUM_BUCKETS) ? 32'h1F :
				(index == REG_BUCKET_SIZE) ? 32'h7 : 32'h3));
		end
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= index;
		cfg.wdata <= wd;
		do begin
			@(posedge clk);
		end while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (index)
			REG_NUM_BUCKETS: m_buckets = wd[4:0];
			REG_BUCKET_SIZE: m_slots = wd[2:0];
			default: m_mode = wd[1:0];
		endcase
		cfg_writes++;
	endtask

	task automatic add_word(input logic cmd, input logic [31:0] key, input logic [31:0] val);
		request_t w;
		w.cmd = cmd;
		w.key = key;
		w.val = val;
		pending_words.push_back(w);
	endtask

	// Edge keys: insert each, search each, then a duplicate and a missing key.
	task automatic edge_words();
		logic [31:0] keys [6];
		keys = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFF, 32'd1};
		foreach (keys[i]) add_word(CMD_INSERT, keys[i], (i % 2) ? 32'hFFFF_FFFF : $urandom());
		foreach (keys[i]) add_word(CMD_SEARCH, keys[i], $urandom());
		add_word(CMD_INSERT, 32'd1, 32'd0);
		add_word(CMD_SEARCH, 32'd1, 32'd0);
		add_word(CMD_SEARCH, 32'h1234_5678, 32'd0);
	endtask

	// Random words around a small pool of keys so that searches hit.
	task automatic random_words(input int count);
		logic [31:0] pool [24];
		logic [31:0] k;
		foreach (pool[i]) pool[i] = ($urandom_range(1)) ? $urandom() : $urandom_range(300);
		for (int n = 0; n < count; n++) begin
			k = ($urandom_range(99) < 75) ? pool[$urandom_range(23)] : $urandom();
			add_word(($urandom_range(99) < 35) ? CMD_INSERT : CMD_SEARCH, k, $urandom());
		end
	endtask

	// Stimulus: phases of register settings, idling and random words.
	initial begin
		logic [4:0] nb_set [8];
		logic [2:0] sz_set [8];
		logic [1:0] hm_set [8];
		nb_set = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16, 5'd7, 5'd13};
		sz_set = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd4, 3'd3, 3'd5};
		hm_set = '{HASH_MOD, HASH_MID, HASH_LIN, HASH_MID, HASH_LIN, HASH_UNUSED,
			HASH_MOD, HASH_LIN};
		errors = 0;
		words_sent = 0;
		answers_seen = 0;
		cfg_writes = 0;
		finds = 0;
		ovf_finds = 0;
		idle_mode = IDLE_NONE;
		hold_kick = 1'b0;
		hold_left = 0;
		m_buckets = 5'd11;
		m_slots = 3'd3;
		m_mode = HASH_MOD;
		foreach (tab_used[i]) tab_used[i] = 1'b0;
		foreach (ovf_used[i]) ovf_used[i] = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.wdata = '0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings first.
		edge_words();
		random_words(60);
		drain();

		for (int p = 0; p < 8; p++) begin
			reg_write(REG_NUM_BUCKETS, nb_set[p]);
			reg_write(REG_BUCKET_SIZE, sz_set[p]);
			reg_write(REG_HASH_MODE, hm_set[p]);
			idle_mode = p % 4;
			if (p == 1) begin
				@(posedge clk);
				hold_kick <= 1'b1;
				@(posedge clk);
				hold_kick <= 1'b0;
			end
			if (p == 1 || p == 5) edge_words();
			random_words(PHASE_ITEMS - ((p == 1 || p == 5) ? 15 : 0));
			drain();
		end

		$display("Covered %0d request words and %0d responses over %0d register writes,",
			words_sent, answers_seen, cfg_writes);
		$display("with %0d bucket hits and %0d overflow hits.", finds, ovf_finds);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#60000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
